// File: rtl/core/pdcm_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the page directory coherence manager.
// Used by every module under rtl/core; depends on nothing.
package pdcm_pkg;

  localparam int NODES  = 8;
  localparam int PAGES  = 1024;
  localparam int NODE_W = 3;
  localparam int PAGE_W = 10;
  localparam int CFG_W  = 11;

  localparam logic [CFG_W-1:0] PAGES_IN_USE_RESET = CFG_W'(PAGES);

  typedef enum logic [2:0] {
    CMD_FETCH_RD   = 3'd0,
    CMD_FETCH_INV  = 3'd1,
    CMD_NO_DATA    = 3'd2,
    CMD_INVALIDATE = 3'd3,
    CMD_ERROR      = 3'd4
  } cmd_t;

  typedef struct packed {
    logic              req_type;
    logic [PAGE_W-1:0] page_number;
    logic [NODE_W-1:0] requester;
  } req_t;

  typedef struct packed {
    cmd_t              command;
    logic [NODE_W-1:0] target_node;
    logic [PAGE_W-1:0] page_out;
    logic              last;
  } res_t;

  typedef struct packed {
    logic [NODE_W-1:0] owner;
    logic [NODES-1:0]  sharers;
  } entry_t;

  typedef struct packed {
    logic             load;
    logic             advance;
    logic [NODES-1:0] set;
  } inv_ctl_t;

  typedef struct packed {
    logic [NODE_W-1:0] node;
    logic              last;
  } inv_stat_t;

endpackage

// File: rtl/core/pdcm_inv_seq.sv
`timescale 1ns / 1ps
// Invalidation sequencer: holds the remaining sharers of a write and
// names the lowest one each cycle. Depends on pdcm_pkg.
module pdcm_inv_seq (
  input  logic                clk,
  input  logic                rst,
  input  pdcm_pkg::inv_ctl_t  ctl,
  output pdcm_pkg::inv_stat_t stat
);

  logic [pdcm_pkg::NODES-1:0]  remaining;
  logic [pdcm_pkg::NODES-1:0]  pick_mask;
  logic [pdcm_pkg::NODE_W-1:0] pick_node;

  always_comb begin
    pick_node = '0;
    for (int i = pdcm_pkg::NODES - 1; i >= 0; i--) begin
      if (remaining[i]) begin
        pick_node = pdcm_pkg::NODE_W'(i);
      end
    end
    pick_mask = pdcm_pkg::NODES'(1) << pick_node;
  end

  assign stat.node = pick_node;
  assign stat.last = (remaining & ~pick_mask) == '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      remaining <= '0;
    end else if (ctl.load) begin
      remaining <= ctl.set;
    end else if (ctl.advance) begin
      remaining <= remaining & ~pick_mask;
    end
  end

endmodule

// File: rtl/core/pdcm_engine.sv
`timescale 1ns / 1ps
// Directory engine: owner/sharer memory, clearing pass, lookup and
// write-back, and the result register. Depends on pdcm_pkg, pdcm_inv_seq.
module pdcm_engine (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  pdcm_pkg::req_t               req,
  input  logic [pdcm_pkg::CFG_W-1:0]   pages_in_use,
  output logic                         result_valid,
  output pdcm_pkg::res_t               result
);

  typedef enum logic [3:0] {
    ST_CLEAR  = 4'b0001,
    ST_IDLE   = 4'b0010,
    ST_LOOKUP = 4'b0100,
    ST_INV    = 4'b1000
  } state_t;

  state_t state, state_next;

  pdcm_pkg::entry_t mem [pdcm_pkg::PAGES];
  pdcm_pkg::entry_t rd_data;
  pdcm_pkg::entry_t wr_data;
  logic [pdcm_pkg::PAGE_W-1:0] wr_addr;
  logic                        wr_en;

  logic [pdcm_pkg::PAGE_W-1:0] clr_addr;
  pdcm_pkg::req_t              req_q;
  pdcm_pkg::res_t              result_next;
  logic                        result_valid_next;

  pdcm_pkg::inv_ctl_t  inv_ctl;
  pdcm_pkg::inv_stat_t inv_stat;

  logic                       accept;
  logic                       page_err;
  logic [pdcm_pkg::NODES-1:0] req_mask;
  logic [pdcm_pkg::NODES-1:0] rest;

  pdcm_inv_seq u_inv_seq (
    .clk  (clk),
    .rst  (rst),
    .ctl  (inv_ctl),
    .stat (inv_stat)
  );

  assign busy     = state != ST_IDLE;
  assign accept   = start && (state == ST_IDLE);
  assign page_err = {1'b0, req_q.page_number} >= pages_in_use;
  assign req_mask = pdcm_pkg::NODES'(1) << req_q.requester;
  assign rest     = rd_data.sharers & ~req_mask;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[req.page_number];
  end

  always_comb begin
    state_next        = state;
    wr_en             = 1'b0;
    wr_addr           = req_q.page_number;
    wr_data           = '0;
    inv_ctl           = '0;
    result_valid_next = 1'b0;
    result_next       = '0;
    result_next.page_out = req_q.page_number;
    unique case (state)
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_addr;
        if (clr_addr == pdcm_pkg::PAGE_W'(pdcm_pkg::PAGES - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        result_valid_next = 1'b1;
        result_next.last  = 1'b1;
        state_next        = ST_IDLE;
        if (page_err) begin
          result_next.command     = pdcm_pkg::CMD_ERROR;
          result_next.target_node = req_q.requester;
        end else if (!req_q.req_type) begin
          result_next.command     = pdcm_pkg::CMD_FETCH_RD;
          result_next.target_node = rd_data.owner;
          wr_en                   = 1'b1;
          wr_data.owner           = rd_data.owner;
          wr_data.sharers         = rd_data.sharers | req_mask;
        end else begin
          result_next.command     = (rd_data.owner == req_q.requester) ?
                                    pdcm_pkg::CMD_NO_DATA : pdcm_pkg::CMD_FETCH_INV;
          result_next.target_node = rd_data.owner;
          result_next.last        = rest == '0;
          wr_en                   = 1'b1;
          wr_data.owner           = req_q.requester;
          inv_ctl.load            = 1'b1;
          inv_ctl.set             = rest;
          if (rest != '0) begin
            state_next = ST_INV;
          end
        end
      end
      ST_INV: begin
        result_valid_next       = 1'b1;
        result_next.command     = pdcm_pkg::CMD_INVALIDATE;
        result_next.target_node = inv_stat.node;
        result_next.last        = inv_stat.last;
        inv_ctl.advance         = 1'b1;
        if (inv_stat.last) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      clr_addr     <= '0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= result_valid_next;
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_q <= req;
    end
    result <= result_next;
  end

endmodule

// File: rtl/core/page_directory_coherence_manager.sv
`timescale 1ns / 1ps
// Top level of the page directory coherence manager: configuration
// register and directory engine. Depends on pdcm_pkg, pdcm_engine.
//
// After reset the block clears its 1024-entry directory memory, one entry
// a cycle, and holds busy high until that pass is done. A request is taken
// when start is high and busy is low. A read request, or any request for a
// page at or above pages_in_use, gives one result; the directory memory
// read is registered, and so is the result. A write request gives its
// first result in the same way and then one invalidation per remaining
// sharer in the following cycles, and busy stays high while they are
// issued. Every result is shown for exactly one cycle with result_valid
// high and cannot be held off, so the receiver must take each word as it
// appears; last marks the final word of a request.
// Configuration writes are always accepted and must be made while idle.
module page_directory_coherence_manager (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  pdcm_pkg::req_t             req,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [pdcm_pkg::CFG_W-1:0] cfg_data,
  output logic                       result_valid,
  output pdcm_pkg::res_t             result
);

  logic [pdcm_pkg::CFG_W-1:0] pages_in_use;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pages_in_use <= pdcm_pkg::PAGES_IN_USE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      pages_in_use <= cfg_data;
    end
  end

  pdcm_engine u_engine (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .req          (req),
    .pages_in_use (pages_in_use),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule
